### design/tlbw_pkg.sv
// Package for the wired-entry TLB model: sizes, command and register codes,
// controller/datapath command struct. No dependencies.
package tlbw_pkg;
   localparam int TLB_SLOTS       = 64;
   localparam int PAGES_PER_TABLE = 512;
   localparam int SLOT_W          = $clog2(TLB_SLOTS);
   localparam int TPB             = $clog2(PAGES_PER_TABLE);
   localparam int TAG_W           = 22;

   localparam logic [1:0] CMD_PROBE  = 2'd0;
   localparam logic [1:0] CMD_FILL   = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [2:0] REG_SHIFT  = 3'd0;
   localparam logic [2:0] REG_PAIR   = 3'd1;
   localparam logic [2:0] REG_WIRED  = 3'd2;
   localparam logic [2:0] REG_RANDOM = 3'd3;
   localparam logic [2:0] REG_HIT    = 3'd4;
   localparam logic [2:0] REG_FIRST  = 3'd5;
   localparam logic [2:0] REG_MIDDLE = 3'd6;
   localparam logic [2:0] REG_SECOND = 3'd7;

   localparam logic [1:0] LVL_FIRST  = 2'd0;
   localparam logic [1:0] LVL_MIDDLE = 2'd1;
   localparam logic [1:0] LVL_SECOND = 2'd2;

   // tag source for a search/insert step
   localparam logic TSRC_PAGE  = 1'b0;
   localparam logic TSRC_TABLE = 1'b1;

   typedef struct packed {
      logic load;        // latch request, compute tags
      logic search;      // search tag_src, latch hit
      logic tag_src;
      logic ins_wired;   // insert tag_src at next wired slot
      logic ins_random;  // insert tag_src at replace pointer
      logic account;     // update counters for the level
      logic [1:0] level;
      logic respond;
   } ctl_type;

   typedef struct packed {
      logic found;
      logic wired_left;
   } sts_type;
endpackage

### design/tlbw_datapath.sv
// Datapath: tag array with match vector, pointers, statistics counters,
// result registers. Uses tlbw_pkg.
module tlbw_datapath import tlbw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl,
   output sts_type             sts,
   input  logic [1:0]          req_command,
   input  logic [31:0]         req_virtual_address,
   input  logic [2:0]          req_counter_select,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data,
   output logic                rsp_strobe,
   output logic                rsp_hit,
   output logic [SLOT_W-1:0]   rsp_entry_index,
   output logic [1:0]          rsp_fill_level,
   output logic [SLOT_W-1:0]   rsp_table_slot,
   output logic                rsp_memory_miss,
   output logic [63:0]         rsp_counter_value
);
   logic [4:0]  shift_ff;
   logic        pair_ff;
   logic [5:0]  wired_ff;
   logic [6:0]  random_ff;
   logic [6:0]  hitpct_ff;
   logic [15:0] pen_first_ff, pen_middle_ff, pen_second_ff;

   logic [TAG_W-1:0]     tag_ff [TLB_SLOTS];
   logic [TLB_SLOTS-1:0] valid_ff;
   logic [6:0]           next_wired_ff;
   logic [SLOT_W-1:0]    ptr_ff;
   logic [6:0]           tally_ff;
   logic [63:0]          cnt_ff [8];

   logic [1:0]        cmd_ff;
   logic [2:0]        sel_ff;
   logic [TAG_W-1:0]  page_ff, table_ff;
   logic              found_ff;
   logic [SLOT_W-1:0] found_idx_ff;
   logic [SLOT_W-1:0] entry_ff, tslot_ff;
   logic              mmiss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 5'd12; pair_ff <= 1'b0; wired_ff <= 6'd7; random_ff <= 7'd56;
         hitpct_ff <= 7'd97; pen_first_ff <= 16'd10; pen_middle_ff <= 16'd177;
         pen_second_ff <= 16'd2000;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SHIFT:  shift_ff      <= csr_data[4:0];
            REG_PAIR:   pair_ff       <= csr_data[0];
            REG_WIRED:  wired_ff      <= csr_data[5:0];
            REG_RANDOM: random_ff     <= csr_data[6:0];
            REG_HIT:    hitpct_ff     <= csr_data[6:0];
            REG_FIRST:  pen_first_ff  <= csr_data[15:0];
            REG_MIDDLE: pen_middle_ff <= csr_data[15:0];
            REG_SECOND: pen_second_ff <= csr_data[15:0];
         endcase
      end
   end

   logic [4:0] eshift;
   always_comb begin
      if (shift_ff < 5'd10)      eshift = 5'd10;
      else if (shift_ff > 5'd16) eshift = 5'd16;
      else                       eshift = shift_ff;
   end

   function automatic logic [TAG_W-1:0] page_of(input logic [31:0] a,
                                                input logic [4:0] s, input logic pr);
      logic [31:0] sh;
      logic [TAG_W-1:0] p;
      sh = a >> s;
      p = sh[TAG_W-1:0];
      if (pr) p[0] = 1'b0;
      return p;
   endfunction

   logic [TAG_W-1:0] vpn_c;
   logic [63:0]      seg_c;
   logic [31:0]      seg_addr_c;
   always_comb begin
      vpn_c      = page_of(req_virtual_address, eshift, pair_ff);
      seg_c      = {{(64-TAG_W+TPB){1'b0}}, vpn_c[TAG_W-1:TPB]} << (eshift + 5'd1);
      seg_addr_c = seg_c[31:0] | 32'h8000_0000;
   end

   // effective slot counts
   logic [6:0] ew, asz;
   logic [7:0] sum;
   always_comb begin
      ew  = (wired_ff > 6'(TLB_SLOTS-1)) ? 7'(TLB_SLOTS-1) : {1'b0, wired_ff};
      sum = {1'b0, ew} + {1'b0, random_ff};
      if (sum > 8'(TLB_SLOTS)) sum = 8'(TLB_SLOTS);
      if (sum <= {1'b0, ew})   sum = {1'b0, ew} + 8'd1;
      asz = sum[6:0];
   end

   logic [TAG_W-1:0] cur_tag;
   assign cur_tag = (ctl.tag_src == TSRC_TABLE) ? table_ff : page_ff;

   logic [TLB_SLOTS-1:0] match;
   always_comb begin
      for (int i = 0; i < TLB_SLOTS; i++)
         match[i] = valid_ff[i] && (tag_ff[i] == cur_tag);
   end

   logic [SLOT_W-1:0] match_idx;
   always_comb begin
      match_idx = '0;
      for (int i = TLB_SLOTS-1; i >= 0; i--)
         if (match[i]) match_idx = SLOT_W'(i);
   end

   logic [6:0] rp;
   always_comb begin
      rp = {{(7-SLOT_W){1'b0}}, ptr_ff};
      if (rp < ew || rp >= asz) rp = asz - 7'd1;
   end

   logic              do_ins;
   logic [SLOT_W-1:0] ins_slot;
   assign do_ins   = ctl.ins_wired | ctl.ins_random;
   assign ins_slot = ctl.ins_wired ? next_wired_ff[SLOT_W-1:0] : rp[SLOT_W-1:0];

   assign sts.found      = found_ff;
   assign sts.wired_left = next_wired_ff < ew;

   logic [13:0] prod;
   logic [6:0]  tally_inc;
   assign tally_inc = tally_ff + 7'd1;
   assign prod = {7'd0, tally_inc} * (14'd100 - {7'd0, hitpct_ff});

   always_ff @(posedge clock) begin
      if (do_ins) tag_ff[ins_slot] <= cur_tag;
      if (ctl.load) begin
         cmd_ff   <= req_command;
         sel_ff   <= req_counter_select;
         page_ff  <= vpn_c;
         table_ff <= page_of(seg_addr_c, eshift, pair_ff);
      end
      if (ctl.search) found_idx_ff <= match_idx;
      if (ctl.ins_wired)  tslot_ff <= ins_slot;
      if (ctl.ins_random) begin
         if (ctl.tag_src == TSRC_TABLE) tslot_ff <= ins_slot;
         else                           entry_ff <= ins_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         next_wired_ff <= '0;
         ptr_ff        <= SLOT_W'(TLB_SLOTS-1);
         tally_ff      <= '0;
         found_ff      <= 1'b0;
         mmiss_ff      <= 1'b0;
         for (int i = 0; i < 8; i++) cnt_ff[i] <= '0;
      end else begin
         if (ctl.load) begin
            mmiss_ff <= 1'b0;
         end
         if (ctl.search) found_ff <= |match;
         if (do_ins) begin
            valid_ff           <= (valid_ff & ~match) | (TLB_SLOTS'(1) << ins_slot);
            cnt_ff[0]          <= cnt_ff[0] + 64'd1;
         end
         if (ctl.ins_wired) next_wired_ff <= next_wired_ff + 7'd1;
         if (ctl.ins_random)
            ptr_ff <= (rp > ew) ? SLOT_W'(rp - 7'd1) : SLOT_W'(asz - 7'd1);
         if (ctl.account) begin
            unique case (ctl.level)
               LVL_FIRST: begin
                  cnt_ff[2] <= cnt_ff[2] + 64'd1;
                  cnt_ff[3] <= cnt_ff[3] + {48'd0, pen_first_ff};
                  if (hitpct_ff < 7'd100) begin
                     if (prod >= 14'd100) begin
                        tally_ff  <= '0;
                        cnt_ff[1] <= cnt_ff[1] + 64'd1;
                        mmiss_ff  <= 1'b1;
                     end else begin
                        tally_ff <= tally_inc;
                     end
                  end
               end
               LVL_MIDDLE: begin
                  cnt_ff[4] <= cnt_ff[4] + 64'd1;
                  cnt_ff[5] <= cnt_ff[5] + {48'd0, pen_middle_ff};
               end
               default: begin
                  cnt_ff[6] <= cnt_ff[6] + 64'd1;
                  cnt_ff[7] <= cnt_ff[7] + {48'd0, pen_second_ff};
               end
            endcase
         end
      end
   end

   logic rsp_strobe_ff;
   logic [1:0] level_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= ctl.respond;
      if (ctl.respond) level_ff <= ctl.level;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_hit           = (cmd_ff == CMD_PROBE) && found_ff;
   assign rsp_entry_index   = (cmd_ff == CMD_PROBE) ? (found_ff ? found_idx_ff : '0) :
                              (cmd_ff == CMD_FILL) ? entry_ff : '0;
   assign rsp_fill_level    = (cmd_ff == CMD_FILL) ? level_ff : LVL_FIRST;
   assign rsp_table_slot    = (cmd_ff == CMD_FILL && level_ff != LVL_FIRST) ? tslot_ff : '0;
   assign rsp_memory_miss   = (cmd_ff == CMD_FILL) && mmiss_ff;
   assign rsp_counter_value = (cmd_ff == CMD_READ) ? cnt_ff[sel_ff] : 64'd0;
endmodule

### design/tlbw_control.sv
// Controller: sequences probe, fill and counter read steps on the datapath.
// Uses tlbw_pkg.
module tlbw_control import tlbw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_command,
   input  sts_type    sts,
   output logic       busy,
   output ctl_type    ctl
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_INS2   = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [1:0] cmd_ff;
   logic [1:0] level_ff, level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         level_ff <= LVL_FIRST;
         cmd_ff   <= CMD_PROBE;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         if (ctl.load) cmd_ff <= req_command;
      end
   end

   assign busy = state_ff != S_IDLE;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      level_in = level_ff;
      ctl.level = level_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && req_command != CMD_UNUSED) begin
               ctl.load = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            ctl.search  = 1'b1;
            ctl.tag_src = (cmd_ff == CMD_FILL) ? TSRC_TABLE : TSRC_PAGE;
            state_in    = (cmd_ff == CMD_FILL) ? S_DECIDE : S_DONE;
            level_in    = LVL_FIRST;
         end
         S_DECIDE: begin
            ctl.tag_src = TSRC_TABLE;
            if (sts.found) begin
               ctl.tag_src    = TSRC_PAGE;
               ctl.ins_random = 1'b1;
               ctl.account    = 1'b1;
               ctl.level      = LVL_FIRST;
               level_in       = LVL_FIRST;
               state_in       = S_DONE;
            end else if (sts.wired_left) begin
               ctl.ins_wired = 1'b1;
               ctl.account   = 1'b1;
               ctl.level     = LVL_SECOND;
               level_in      = LVL_SECOND;
               state_in      = S_INS2;
            end else begin
               ctl.ins_random = 1'b1;
               ctl.account    = 1'b1;
               ctl.level      = LVL_MIDDLE;
               level_in       = LVL_MIDDLE;
               state_in       = S_INS2;
            end
         end
         S_INS2: begin
            ctl.tag_src    = TSRC_PAGE;
            ctl.ins_random = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            ctl.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

### design/tlb_wired_random_fill_model.sv
// Top level of the wired-entry TLB model: joins controller and datapath.
// Uses tlbw_pkg, tlbw_control, tlbw_datapath.
//
// Usage:
//  Request: drive req_command, req_virtual_address, req_counter_select and
//  raise start; the beat is taken at an edge where start is high and busy
//  is low. Command 3 is dropped and leaves busy low.
//  Response: rsp_strobe is high for one cycle with all rsp_ fields valid;
//  the receiver cannot stall and must take it in that cycle.
//  Sequence: probe and counter read pass SEARCH and DONE; a fill passes
//  SEARCH, DECIDE, then DONE at first level or INS2 and DONE for second
//  and middle fills; the strobe is registered from DONE. busy stays high
//  until the strobe cycle, so one item is in flight; the search and insert
//  steps all use the single tag array. The next beat is taken at the
//  earliest at the edge that ends the strobe cycle.
//  Configuration: csr_valid/csr_ready (always high) with csr_index and
//  csr_data; the user must write only while the block is idle (unenforced).
//  Reset: synchronous, active high; resets valid bits, pointers, tally and
//  counters and restores register defaults.
module tlb_wired_random_fill_model import tlbw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_command,
   input  logic [31:0]       req_virtual_address,
   input  logic [2:0]        req_counter_select,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   output logic              rsp_strobe,
   output logic              rsp_hit,
   output logic [SLOT_W-1:0] rsp_entry_index,
   output logic [1:0]        rsp_fill_level,
   output logic [SLOT_W-1:0] rsp_table_slot,
   output logic              rsp_memory_miss,
   output logic [63:0]       rsp_counter_value
);
   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   tlbw_control u_control (
      .clock(clock), .reset(reset), .start(start), .req_command(req_command),
      .sts(sts), .busy(busy), .ctl(ctl)
   );

   tlbw_datapath u_datapath (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .req_command(req_command), .req_virtual_address(req_virtual_address),
      .req_counter_select(req_counter_select),
      .csr_we(csr_valid & csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_strobe(rsp_strobe), .rsp_hit(rsp_hit), .rsp_entry_index(rsp_entry_index),
      .rsp_fill_level(rsp_fill_level), .rsp_table_slot(rsp_table_slot),
      .rsp_memory_miss(rsp_memory_miss), .rsp_counter_value(rsp_counter_value)
   );

`ifndef NO_ASSERTIONS
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("response while busy");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command != CMD_UNUSED) |=> busy)
      else $error("accept without busy");
   a_hit_probe: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> rsp_fill_level == LVL_FIRST) else $error("hit on fill");
`endif
endmodule
